### sv/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BCB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in a cycle implies a condition in the next cycle
`define BCB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### sv/bcb_pkg.sv
// types and constants for the bracket and keyword balance checker
// no dependencies
package bcb_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;

  typedef enum logic [1:0] {
    KIND_BRACE  = 2'd0,
    KIND_PAREN  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_BEGIN  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    SOP_HOLD  = 3'd0,
    SOP_PUSH1 = 3'd1,
    SOP_PUSH2 = 3'd2,
    SOP_POP1  = 3'd3,
    SOP_POP2  = 3'd4,
    SOP_REPL  = 3'd5
  } sop_t;

  typedef struct packed {
    sop_t  op;
    kind_t k0;
    kind_t k1;
  } stack_cmd_t;

  typedef struct packed {
    logic balanced;
    logic overflowed;
  } result_t;

endpackage

### sv/bcb_cell.sv
// one stack cell: holds one opener kind and shifts with its neighbors
// depends on bcb_pkg
module bcb_cell (
  input  logic              clk,
  input  bcb_pkg::sop_t     op,
  input  bcb_pkg::kind_t    in_near,
  input  bcb_pkg::kind_t    in_far,
  input  bcb_pkg::kind_t    in_below1,
  input  bcb_pkg::kind_t    in_below2,
  output bcb_pkg::kind_t    kind
);

  bcb_pkg::kind_t kind_r;
  bcb_pkg::kind_t kind_nxt;

  always_comb begin
    unique case (op)
      bcb_pkg::SOP_PUSH1: kind_nxt = in_near;
      bcb_pkg::SOP_PUSH2: kind_nxt = in_far;
      bcb_pkg::SOP_POP1:  kind_nxt = in_below1;
      bcb_pkg::SOP_POP2:  kind_nxt = in_below2;
      default:            kind_nxt = kind_r;
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind = kind_r;

endmodule

### sv/bcb_ctrl.sv
// word tracking, stack level, failure flags and stack command decode
// depends on bcb_pkg
module bcb_ctrl #(
  parameter int STACK_DEPTH = bcb_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  input  logic                byte_present,
  input  logic                end_of_text,
  input  bcb_pkg::kind_t      top0,
  input  bcb_pkg::kind_t      top1,
  output bcb_pkg::stack_cmd_t cmd,
  output bcb_pkg::result_t    res
);

  localparam int LW = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_E       = 8'h65;
  localparam logic [7:0] CH_G       = 8'h67;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;

  typedef enum logic [3:0] {
    W_OUT   = 4'd0,
    W_B     = 4'd1,
    W_BE    = 4'd2,
    W_BEG   = 4'd3,
    W_BEGI  = 4'd4,
    W_BEGIN = 4'd5,
    W_E     = 4'd6,
    W_EN    = 4'd7,
    W_END   = 4'd8,
    W_OTHER = 4'd9
  } word_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_PUSH = 2'd1,
    ACT_POP  = 2'd2
  } act_t;

  function automatic word_t next_word(input word_t w, input logic [7:0] c);
    word_t r;
    r = W_OTHER;
    unique case (w)
      W_OUT:   r = (c == CH_B) ? W_B : ((c == CH_E) ? W_E : W_OTHER);
      W_B:     r = (c == CH_E) ? W_BE : W_OTHER;
      W_BE:    r = (c == CH_G) ? W_BEG : W_OTHER;
      W_BEG:   r = (c == CH_I) ? W_BEGI : W_OTHER;
      W_BEGI:  r = (c == CH_N) ? W_BEGIN : W_OTHER;
      W_E:     r = (c == CH_N) ? W_EN : W_OTHER;
      W_EN:    r = (c == CH_D) ? W_END : W_OTHER;
      default: r = W_OTHER;
    endcase
    return r;
  endfunction

  word_t            word_r;
  word_t            word_nxt;
  logic [LW-1:0]    level_r;
  logic [LW-1:0]    level_nxt;
  logic             failed_r;
  logic             failed_nxt;
  logic             ovf_r;
  logic             ovf_nxt;

  word_t            wf;
  logic             letter;
  logic             finish;
  act_t             a1;
  act_t             a2;
  bcb_pkg::kind_t   bk;
  logic             full;
  logic             empty;
  logic [LW-1:0]    lvl_op;
  logic             fail_op;
  logic             ovf_op;

  always_comb begin
    letter = ((text_byte >= CH_LO_A) && (text_byte <= CH_LO_Z)) ||
             ((text_byte >= CH_UP_A) && (text_byte <= CH_UP_Z));
    wf = word_r;
    if (byte_present && letter) begin
      wf = next_word(word_r, text_byte);
    end
    finish = (byte_present && !letter) || end_of_text;

    a1 = ACT_NONE;
    if (finish && (wf == W_BEGIN)) begin
      a1 = ACT_PUSH;
    end else if (finish && (wf == W_END)) begin
      a1 = ACT_POP;
    end

    a2 = ACT_NONE;
    bk = bcb_pkg::KIND_BRACE;
    if (byte_present && !letter) begin
      unique case (text_byte)
        CH_LBRACE: begin
          a2 = ACT_PUSH;
          bk = bcb_pkg::KIND_BRACE;
        end
        CH_LPAREN: begin
          a2 = ACT_PUSH;
          bk = bcb_pkg::KIND_PAREN;
        end
        CH_LSQUARE: begin
          a2 = ACT_PUSH;
          bk = bcb_pkg::KIND_SQUARE;
        end
        CH_RBRACE: begin
          a2 = ACT_POP;
          bk = bcb_pkg::KIND_BRACE;
        end
        CH_RPAREN: begin
          a2 = ACT_POP;
          bk = bcb_pkg::KIND_PAREN;
        end
        CH_RSQUARE: begin
          a2 = ACT_POP;
          bk = bcb_pkg::KIND_SQUARE;
        end
        default: begin
          a2 = ACT_NONE;
          bk = bcb_pkg::KIND_BRACE;
        end
      endcase
    end

    full  = (level_r == LW'(STACK_DEPTH));
    empty = (level_r == '0);

    cmd.op  = bcb_pkg::SOP_HOLD;
    cmd.k0  = bk;
    cmd.k1  = bcb_pkg::KIND_BEGIN;
    lvl_op  = level_r;
    fail_op = failed_r;
    ovf_op  = ovf_r;

    if (accept && !failed_r) begin
      unique case (a1)
        ACT_PUSH: begin
          if (full) begin
            fail_op = 1'b1;
            ovf_op  = 1'b1;
          end else if (a2 == ACT_PUSH) begin
            if (level_r == LW'(STACK_DEPTH - 1)) begin
              fail_op = 1'b1;
              ovf_op  = 1'b1;
            end else begin
              cmd.op = bcb_pkg::SOP_PUSH2;
              lvl_op = level_r + LW'(2);
            end
          end else if (a2 == ACT_POP) begin
            // a bracket closer right after begin never matches
            fail_op = 1'b1;
          end else begin
            cmd.op = bcb_pkg::SOP_PUSH1;
            cmd.k0 = bcb_pkg::KIND_BEGIN;
            lvl_op = level_r + LW'(1);
          end
        end
        ACT_POP: begin
          if (empty || (top0 != bcb_pkg::KIND_BEGIN)) begin
            fail_op = 1'b1;
          end else if (a2 == ACT_PUSH) begin
            cmd.op = bcb_pkg::SOP_REPL;
          end else if (a2 == ACT_POP) begin
            if ((level_r == LW'(1)) || (top1 != bk)) begin
              fail_op = 1'b1;
            end else begin
              cmd.op = bcb_pkg::SOP_POP2;
              lvl_op = level_r - LW'(2);
            end
          end else begin
            cmd.op = bcb_pkg::SOP_POP1;
            lvl_op = level_r - LW'(1);
          end
        end
        default: begin
          if (a2 == ACT_PUSH) begin
            if (full) begin
              fail_op = 1'b1;
              ovf_op  = 1'b1;
            end else begin
              cmd.op = bcb_pkg::SOP_PUSH1;
              lvl_op = level_r + LW'(1);
            end
          end else if (a2 == ACT_POP) begin
            if (empty || (top0 != bk)) begin
              fail_op = 1'b1;
            end else begin
              cmd.op = bcb_pkg::SOP_POP1;
              lvl_op = level_r - LW'(1);
            end
          end
        end
      endcase
    end

    res.balanced   = !fail_op && (lvl_op == '0);
    res.overflowed = ovf_op;

    word_nxt   = word_r;
    level_nxt  = level_r;
    failed_nxt = failed_r;
    ovf_nxt    = ovf_r;
    if (accept) begin
      word_nxt   = finish ? W_OUT : wf;
      level_nxt  = lvl_op;
      failed_nxt = fail_op;
      ovf_nxt    = ovf_op;
      if (end_of_text) begin
        word_nxt   = W_OUT;
        level_nxt  = '0;
        failed_nxt = 1'b0;
        ovf_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r   <= W_OUT;
      level_r  <= '0;
      failed_r <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      word_r   <= word_nxt;
      level_r  <= level_nxt;
      failed_r <= failed_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

### sv/bracket_and_keyword_balance_checker.sv
// top level: control, row of stack cells and the result register
// depends on bcb_pkg, bcb_ctrl, bcb_cell and assert_macros.svh
//
//   port group   direction   carries
//   in_*         input       one text byte, presence flag and end-of-text flag per beat
//   out_*        output      balanced and overflowed, one beat per text
//
// one input beat per cycle while in_ready; the result is out the cycle after a text ends
// the stack is a row of shifting cells, so each beat's push or pop is in place for the next beat
// reset is synchronous; stack cells need no clearing
// a result waiting with out_ready low holds back only the next end-of-text beat
module bracket_and_keyword_balance_checker #(
  parameter int STACK_DEPTH = bcb_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_balanced,
  output logic       out_overflowed
);

  `include "assert_macros.svh"

  logic                out_valid_r;
  logic                out_balanced_r;
  logic                out_overflowed_r;
  logic                in_acc;
  bcb_pkg::stack_cmd_t cmd;
  bcb_pkg::result_t    res;
  bcb_pkg::kind_t      kind_w [STACK_DEPTH];

  assign in_ready = rst_n && (!out_valid_r || out_ready || !in_end_of_text);
  assign in_acc   = in_valid && in_ready;

  bcb_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .text_byte   (in_text_byte),
    .byte_present(in_byte_present),
    .end_of_text (in_end_of_text),
    .top0        (kind_w[0]),
    .top1        (kind_w[1]),
    .cmd         (cmd),
    .res         (res)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    bcb_pkg::sop_t  op_w;
    bcb_pkg::kind_t near_w;
    bcb_pkg::kind_t far_w;
    bcb_pkg::kind_t below1_w;
    bcb_pkg::kind_t below2_w;

    if (i == 0) begin : g_top
      assign op_w   = (cmd.op == bcb_pkg::SOP_REPL) ? bcb_pkg::SOP_PUSH1 : cmd.op;
      assign near_w = cmd.k0;
      assign far_w  = cmd.k0;
    end else if (i == 1) begin : g_second
      assign op_w   = (cmd.op == bcb_pkg::SOP_REPL) ? bcb_pkg::SOP_HOLD : cmd.op;
      assign near_w = kind_w[0];
      assign far_w  = cmd.k1;
    end else begin : g_mid
      assign op_w   = (cmd.op == bcb_pkg::SOP_REPL) ? bcb_pkg::SOP_HOLD : cmd.op;
      assign near_w = kind_w[i-1];
      assign far_w  = kind_w[i-2];
    end

    if (i + 1 < STACK_DEPTH) begin : g_b1
      assign below1_w = kind_w[i+1];
    end else begin : g_b1_end
      assign below1_w = kind_w[i];
    end

    if (i + 2 < STACK_DEPTH) begin : g_b2
      assign below2_w = kind_w[i+2];
    end else begin : g_b2_end
      assign below2_w = kind_w[i];
    end

    bcb_cell u_cell (
      .clk      (clk),
      .op       (op_w),
      .in_near  (near_w),
      .in_far   (far_w),
      .in_below1(below1_w),
      .in_below2(below2_w),
      .kind     (kind_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && in_end_of_text) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_end_of_text) begin
      out_balanced_r   <= res.balanced;
      out_overflowed_r <= res.overflowed;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_balanced   = out_balanced_r;
  assign out_overflowed = out_overflowed_r;

  `BCB_ASSERT_NEXT(a_result_follows_end, clk, rst_n,
                   in_acc && in_end_of_text, out_valid, "no result after end of text")
  `BCB_ASSERT(a_ovf_not_balanced, clk, rst_n,
              !(out_valid && out_balanced && out_overflowed), "overflowed text reported balanced")
  `BCB_ASSERT(a_stack_idle, clk, rst_n,
              in_acc || (cmd.op == bcb_pkg::SOP_HOLD), "stack moved without an input beat")

endmodule

### tb/balance_verdict_checker.sv
// checker for the bracket and keyword balance checker: predicts one verdict per text
// from the accepted input beats and compares it with each accepted result beat
// depends on bcb_pkg
module balance_verdict_checker #(
  parameter int STACK_DEPTH = bcb_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_text,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_balanced,
  input  logic       out_overflowed,
  output int         mismatches,
  output int         pending
);

  typedef enum logic [3:0] {
    W_OUT, W_B, W_BE, W_BEG, W_BEGI, W_BEGIN, W_E, W_EN, W_END, W_OTHER
  } word_t;

  bcb_pkg::kind_t   opener_mem [STACK_DEPTH];
  int               nest_level;
  word_t            word_state;
  bit               stuck_failed;
  bit               overflow_hit;
  bcb_pkg::result_t verdict_q [$];
  int               fail_count = 0;
  int               text_idx = 0;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic word_t advance_word(word_t w, logic [7:0] c);
    case (w)
      W_OUT:   return (c == "b") ? W_B : ((c == "e") ? W_E : W_OTHER);
      W_B:     return (c == "e") ? W_BE : W_OTHER;
      W_BE:    return (c == "g") ? W_BEG : W_OTHER;
      W_BEG:   return (c == "i") ? W_BEGI : W_OTHER;
      W_BEGI:  return (c == "n") ? W_BEGIN : W_OTHER;
      W_E:     return (c == "n") ? W_EN : W_OTHER;
      W_EN:    return (c == "d") ? W_END : W_OTHER;
      default: return W_OTHER;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH: %s", what);
    fail_count++;
  endtask

  task automatic clear_text();
    nest_level   = 0;
    word_state   = W_OUT;
    stuck_failed = 1'b0;
    overflow_hit = 1'b0;
  endtask

  task automatic push_opener(input bcb_pkg::kind_t k);
    if (!stuck_failed) begin
      if (nest_level >= STACK_DEPTH) begin
        stuck_failed = 1'b1;
        overflow_hit = 1'b1;
      end else begin
        opener_mem[nest_level] = k;
        nest_level++;
      end
    end
  endtask

  task automatic pop_opener(input bcb_pkg::kind_t k);
    if (!stuck_failed) begin
      if (nest_level == 0 || opener_mem[nest_level-1] != k) begin
        stuck_failed = 1'b1;
      end else begin
        nest_level--;
      end
    end
  endtask

  task automatic close_word();
    if (word_state == W_BEGIN) push_opener(bcb_pkg::KIND_BEGIN);
    else if (word_state == W_END) pop_opener(bcb_pkg::KIND_BEGIN);
    word_state = W_OUT;
  endtask

  task automatic predict_beat(input logic [7:0] c, input logic present, input logic last);
    bcb_pkg::result_t want;
    if (present) begin
      if (is_letter(c)) begin
        word_state = advance_word(word_state, c);
      end else begin
        close_word();
        case (c)
          "{":     push_opener(bcb_pkg::KIND_BRACE);
          "(":     push_opener(bcb_pkg::KIND_PAREN);
          "[":     push_opener(bcb_pkg::KIND_SQUARE);
          "}":     pop_opener(bcb_pkg::KIND_BRACE);
          ")":     pop_opener(bcb_pkg::KIND_PAREN);
          "]":     pop_opener(bcb_pkg::KIND_SQUARE);
          default: ;
        endcase
      end
    end
    if (last) begin
      close_word();
      want.balanced   = !stuck_failed && nest_level == 0;
      want.overflowed = overflow_hit;
      verdict_q.push_back(want);
      clear_text();
    end
  endtask

  task automatic check_verdict();
    bcb_pkg::result_t want;
    if (verdict_q.size() == 0) begin
      flag_mismatch("result beat with no text waiting");
    end else begin
      want = verdict_q.pop_front();
      if (out_balanced !== want.balanced)
        flag_mismatch($sformatf("text %0d: balanced is %b, expected %b",
                                text_idx, out_balanced, want.balanced));
      if (out_overflowed !== want.overflowed)
        flag_mismatch($sformatf("text %0d: overflowed is %b, expected %b",
                                text_idx, out_overflowed, want.overflowed));
      text_idx++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_text();
      verdict_q.delete();
    end else begin
      if (out_valid && out_ready) check_verdict();
      if (in_valid && in_ready) predict_beat(in_text_byte, in_byte_present, in_end_of_text);
    end
    mismatches <= fail_count;
    pending    <= verdict_q.size();
  end

endmodule

### tb/bracket_and_keyword_balance_checker_tb.sv
// testbench top: clock, reset, text stimulus and random stalls on both channels
// depends on bcb_pkg, bracket_and_keyword_balance_checker and balance_verdict_checker
module bracket_and_keyword_balance_checker_tb;

  localparam int STACK_DEPTH  = bcb_pkg::DEFAULT_STACK_DEPTH;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int MIN_TEXTS    = 60;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_byte_present = 1'b0;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_balanced;
  logic       out_overflowed;

  bit         calm = 1'b0;
  int         mismatches;
  int         expected_left;
  int         cycles = 0;
  int         items_sent = 0;
  logic [7:0] text_q [$];

  string filler_words [12] = '{"beginx", "Begin", "END", "en", "bend", "ebegin",
                               "x", "foo", "ended", "begi", "e", "b"};

  bracket_and_keyword_balance_checker #(.STACK_DEPTH(STACK_DEPTH)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_byte_present(in_byte_present),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_balanced   (out_balanced),
    .out_overflowed (out_overflowed)
  );

  balance_verdict_checker #(.STACK_DEPTH(STACK_DEPTH)) i_verdict_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_byte_present(in_byte_present),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_balanced   (out_balanced),
    .out_overflowed (out_overflowed),
    .mismatches     (mismatches),
    .pending        (expected_left)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 19);
  end

  task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
    if (!calm) begin
      while ($urandom_range(99) < 19) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_text_byte    <= b;
    in_byte_present <= present;
    in_end_of_text  <= last;
    do @(posedge clk); while (!in_ready);
    if (present || last) items_sent++;
  endtask

  // bare_end closes the text with a beat that carries no byte
  task automatic send_text(input bit bare_end, input bit sprinkle);
    for (int i = 0; i < text_q.size(); i++) begin
      if (sprinkle && $urandom_range(99) < 4) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(text_q[i], 1'b1, !bare_end && i == text_q.size() - 1);
    end
    if (bare_end || text_q.size() == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
    text_q.delete();
  endtask

  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_sep();
    string seps;
    seps = " ;\n\t,.0=+*";
    text_q.push_back(seps[$urandom_range(seps.len() - 1)]);
  endtask

  task automatic add_opener(input bcb_pkg::kind_t k);
    case (k)
      bcb_pkg::KIND_BRACE:  add_str("{");
      bcb_pkg::KIND_PAREN:  add_str("(");
      bcb_pkg::KIND_SQUARE: add_str("[");
      default: begin
        add_str("begin");
        add_sep();
      end
    endcase
  endtask

  task automatic add_closer(input bcb_pkg::kind_t k);
    case (k)
      bcb_pkg::KIND_BRACE:  add_str("}");
      bcb_pkg::KIND_PAREN:  add_str(")");
      bcb_pkg::KIND_SQUARE: add_str("]");
      default: begin
        add_str("end");
        add_sep();
      end
    endcase
  endtask

  task automatic add_filler();
    int pick;
    pick = $urandom_range(9);
    if (pick <= 5) begin
      add_str(filler_words[$urandom_range(11)]);
      add_sep();
    end else if (pick == 6) begin
      repeat ($urandom_range(1, 6))
        text_q.push_back(8'($urandom_range(1) ? $urandom_range("a", "z")
                                              : $urandom_range("A", "Z")));
      add_sep();
    end else if (pick == 7) begin
      text_q.push_back(8'($urandom_range(128, 255)));
    end else if (pick == 8) begin
      text_q.push_back(8'($urandom_range(127)));
    end else begin
      add_sep();
    end
  endtask

  task automatic build_nested_text();
    bcb_pkg::kind_t open_kinds [$];
    bcb_pkg::kind_t k;
    int             r;
    repeat ($urandom_range(1, 20)) begin
      r = $urandom_range(99);
      if (r < 35) begin
        k = bcb_pkg::kind_t'($urandom_range(3));
        add_opener(k);
        open_kinds.push_back(k);
      end else if (r < 70 && open_kinds.size() > 0) begin
        k = open_kinds.pop_back();
        if ($urandom_range(99) < 5) k = bcb_pkg::kind_t'($urandom_range(3));
        add_closer(k);
      end else begin
        add_filler();
      end
    end
    if ($urandom_range(99) >= 15)
      while (open_kinds.size() > 0) add_closer(open_kinds.pop_back());
    if ($urandom_range(99) < 5) add_closer(bcb_pkg::kind_t'($urandom_range(3)));
    // let end of text finish the last word
    if (text_q.size() > 1 && text_q[$-1] >= "a" && text_q[$-1] <= "z" &&
        $urandom_range(99) < 40)
      void'(text_q.pop_back());
  endtask

  task automatic build_deep_text();
    bcb_pkg::kind_t open_kinds [$];
    bcb_pkg::kind_t k;
    repeat ($urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 4)) begin
      k = ($urandom_range(7) == 0) ? bcb_pkg::KIND_BEGIN : bcb_pkg::kind_t'($urandom_range(2));
      add_opener(k);
      open_kinds.push_back(k);
    end
    while (open_kinds.size() > 0) add_closer(open_kinds.pop_back());
  endtask

  initial begin
    int rand_texts;
    int mode;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed texts
    add_str("([{}])");
    send_text(1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_text(1'b1, 1'b0);
    add_str("begin end");
    send_text(1'b0, 1'b0);
    add_str(")");
    send_text(1'b0, 1'b0);
    text_q.push_back(8'h00);
    add_str("(]");
    text_q.push_back(8'hFF);
    send_text(1'b1, 1'b0);
    add_str("begin");
    send_text(1'b0, 1'b0);
    wait_for_verdicts();

    items_sent = 0;
    rand_texts = 0;
    while (items_sent < RANDOM_ITEMS || rand_texts < MIN_TEXTS) begin
      calm <= (rand_texts >= 20 && rand_texts < 30);
      if (rand_texts == 12) wait_for_verdicts();
      mode = $urandom_range(99);
      if (mode < 10) begin
        repeat ($urandom_range(1, 30)) text_q.push_back(8'($urandom_range(255)));
      end else if (mode < 16) begin
        build_deep_text();
      end else begin
        build_nested_text();
      end
      send_text($urandom_range(99) < 40, 1'b1);
      rand_texts++;
    end

    calm <= 1'b0;
    wait_for_verdicts();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
